### src/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants, codes and types of the trie word store.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

    localparam int NODE_COUNT = 4096;
    localparam int ALPHABET   = 26;

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int FREE_W   = $clog2(NODE_COUNT + 1);
    localparam int LETTER_W = 5;
    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_FIRST    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPEAT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FIND   = 1'b1;

    typedef logic [NODE_W-1:0] link_t;

    // one table row per node: flags and one child link per letter
    typedef struct packed {
        logic                       reported;
        logic                       word_end;
        link_t [ALPHABET-1:0]       links;
    } row_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic look;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic in_skip;
        logic look_ok;
        logic last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

### src/tws_if.sv
// ----------------------------------------------------------------------------
// tws_in_if / tws_out_if
// Valid/ready channels carrying letter words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tws_in_if
    import tws_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic                func;
    logic [LETTER_W-1:0] letter;
    logic                last;

    modport source (output valid, output func, output letter, output last, input ready);
    modport sink   (input valid, input func, input letter, input last, output ready);
endinterface

interface tws_out_if
    import tws_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

### src/trie_word_store_with_repeat_flag.sv
// ----------------------------------------------------------------------------
// trie_word_store_with_repeat_flag
// Lowercase word store kept as a trie in a node table; insert and find words
// one letter per word on the input channel, one status word per input word.
// ----------------------------------------------------------------------------
// result path: after the last letter is accepted come its table row lookup, the
//   flag update and the result load; a failed walk goes from the skipped letter or
//   the failed lookup to the result load, which waits for room in the output register
// per letter: accept, then the dependent table row lookup; a letter skipped after
//   a failure is only accepted, and no letter is taken while a lookup is under way
// after reset a clearing pass writes all 4096 rows (one per cycle), ready low
`default_nettype none

module trie_word_store_with_repeat_flag
    import tws_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tws_in_if.sink     letter_word,
    tws_out_if.source  status_word
);

    cmd_t  cmd;
    stat_t st;

    tws_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (letter_word.valid),
        .word_ready (letter_word.ready),
        .st         (st),
        .cmd        (cmd)
    );

    tws_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_func     (letter_word.func),
        .word_letter   (letter_word.letter),
        .word_last     (letter_word.last),
        .cmd           (cmd),
        .st            (st),
        .result_valid  (status_word.valid),
        .result_ready  (status_word.ready),
        .result_status (status_word.status)
    );

endmodule

`default_nettype wire

### src/tws_ctrl.sv
// ----------------------------------------------------------------------------
// tws_ctrl
// Sequencer: table clearing, letter lookup, word finish and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_ctrl
    import tws_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  word_valid,
    output logic       word_ready,
    input  wire stat_t st,
    output cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_FIN   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        word_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                word_ready = 1'b1;
                if (word_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.in_skip)
                    begin
                        state_next = st.last ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                cmd.look = 1'b1;
                if (!st.last)
                begin
                    state_next = S_IDLE;
                end
                else if (st.look_ok)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("result emitted while output register busy");

    a_look_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.look |-> $past(cmd.accept))
        else $error("lookup without a fresh letter");

    a_finish_after_look: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> $past(cmd.look))
        else $error("finish without a preceding lookup");

endmodule

`default_nettype wire

### src/tws_dp.sv
// ----------------------------------------------------------------------------
// tws_dp
// Node table memory, walk registers, free-node counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_dp
    import tws_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                word_func,
    input  wire logic [LETTER_W-1:0] word_letter,
    input  wire logic                word_last,
    input  wire cmd_t                cmd,
    output stat_t                    st,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output logic [STATUS_W-1:0]      result_status
);

    row_t mem [NODE_COUNT];

    logic                func_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic                last_reg;
    logic [STATUS_W-1:0] res_reg;
    logic [STATUS_W-1:0] res_next;
    row_t                rd_row_reg;

    link_t               cur_node_reg;
    link_t               cur_node_next;
    logic [FREE_W-1:0]   free_reg;
    logic [FREE_W-1:0]   free_next;
    logic                failed_reg;
    logic                failed_next;
    link_t               clr_cnt_reg;
    link_t               clr_cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;

    logic                wr_en;
    link_t               wr_addr;
    row_t                wr_row;
    link_t               rd_addr;
    link_t               link;
    logic                full;
    logic                bad_letter;

    assign full       = (free_reg == FREE_W'(NODE_COUNT));
    assign bad_letter = (word_letter >= LETTER_W'(ALPHABET));

    always_comb
    begin
        link = '0;
        for (int i = 0; i < ALPHABET; i++)
        begin
            if (letter_reg == LETTER_W'(i))
            begin
                link = rd_row_reg.links[i];
            end
        end
    end

    always_comb
    begin
        cur_node_next   = cur_node_reg;
        free_next       = free_reg;
        failed_next     = failed_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_node_reg;
        wr_row          = rd_row_reg;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.clear_step)
        begin
            wr_en        = 1'b1;
            wr_addr      = clr_cnt_reg;
            wr_row       = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end

        if (cmd.accept && bad_letter)
        begin
            failed_next = 1'b1;
        end

        if (cmd.look)
        begin
            if (link == '0)
            begin
                if (func_reg == FUNC_FIND || full)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    // absent link: hang a fresh node under the current one
                    wr_en = 1'b1;
                    for (int i = 0; i < ALPHABET; i++)
                    begin
                        if (letter_reg == LETTER_W'(i))
                        begin
                            wr_row.links[i] = free_reg[NODE_W-1:0];
                        end
                    end
                    cur_node_next = free_reg[NODE_W-1:0];
                    free_next     = free_reg + 1'b1;
                end
            end
            else
            begin
                cur_node_next = link;
            end
        end

        if (cmd.finish)
        begin
            if (func_reg == FUNC_FIND)
            begin
                if (!rd_row_reg.word_end)
                begin
                    res_next = ST_MISSING;
                end
                else if (!rd_row_reg.reported)
                begin
                    res_next        = ST_FIRST;
                    wr_en           = 1'b1;
                    wr_row.reported = 1'b1;
                end
                else
                begin
                    res_next = ST_REPEAT;
                end
            end
            else
            begin
                res_next        = ST_INSERTED;
                wr_en           = 1'b1;
                wr_row.word_end = 1'b1;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (failed_reg)
            begin
                out_status_next = (func_reg == FUNC_FIND) ? ST_MISSING : ST_FULL;
            end
            else
            begin
                out_status_next = res_reg;
            end
            cur_node_next = '0;
            failed_next   = 1'b0;
        end
    end

    // during a lookup the next row read already targets the node just reached
    assign rd_addr = cmd.look ? cur_node_next : cur_node_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        rd_row_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg   <= word_func;
            letter_reg <= word_letter;
            last_reg   <= word_last;
        end
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_node_reg  <= '0;
            free_reg      <= FREE_W'(1);
            failed_reg    <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_node_reg  <= cur_node_next;
            free_reg      <= free_next;
            failed_reg    <= failed_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        st.clear_done = (clr_cnt_reg == NODE_W'(NODE_COUNT - 1));
        st.in_skip    = failed_reg || bad_letter;
        st.look_ok    = !((link == '0) && (func_reg == FUNC_FIND || full));
        st.last       = cmd.accept ? word_last : last_reg;
        st.out_free   = !out_valid_reg || result_ready;
    end

    assign result_valid  = out_valid_reg;
    assign result_status = out_status_reg;

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg >= FREE_W'(1)) && (free_reg <= FREE_W'(NODE_COUNT)))
        else $error("free node counter out of range");

    a_cur_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_node_reg} < {1'b0, free_reg})
        else $error("walk reached a node that was never allocated");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg != $past(free_reg)) |-> $past(cmd.look))
        else $error("free counter moved outside a lookup");

endmodule

`default_nettype wire
